### rtl/mcpt_pkg.sv
// ============================================================================
// mcpt_pkg
// Shared types, constants and helpers of the multi-channel periodic timer.
// ============================================================================
package mcpt_pkg;

    localparam int TIME_W   = 48;
    localparam int PERIOD_W = 32;
    localparam int CHAN_W   = 6;

    localparam logic [TIME_W-1:0]   TIME_MAX      = {TIME_W{1'b1}};
    localparam logic [PERIOD_W-1:0] QUANTUM_RESET = PERIOD_W'(100);

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_ADD  = 1'b1;
    localparam logic KIND_FIRE = 1'b0;
    localparam logic KIND_ADD  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    // What one cell hands to the next: the scan token and the running minimum.
    typedef struct packed {
        logic              tok;
        logic [TIME_W-1:0] min_dl;
    } t_link;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

endpackage

### rtl/mcpt_cell.sv
// ============================================================================
// mcpt_cell
// One channel slot: holds deadline and period, checks and advances the deadline when
// the scan token passes, and folds its deadline into the running minimum.
// ============================================================================
module mcpt_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_active,
    input  logic [mcpt_pkg::TIME_W-1:0]       i_now,
    input  logic                              i_wr,
    input  logic [mcpt_pkg::TIME_W-1:0]       i_wr_deadline,
    input  logic [mcpt_pkg::PERIOD_W-1:0]     i_wr_period,
    input  mcpt_pkg::t_link                   i_link,
    output mcpt_pkg::t_link                   o_link,
    output logic                              o_fire
);

    logic [mcpt_pkg::TIME_W-1:0]   r_deadline;
    logic [mcpt_pkg::PERIOD_W-1:0] r_period;
    mcpt_pkg::t_link               r_link;
    logic                          r_fire;

    logic                          w_due;
    logic [mcpt_pkg::TIME_W-1:0]   w_new_dl;
    mcpt_pkg::t_link               n_link;
    logic                          n_fire;

    always_comb begin
        w_due    = i_active && (r_deadline <= i_now);
        w_new_dl = w_due ? mcpt_pkg::sat_add(r_deadline,
                                             mcpt_pkg::TIME_W'(r_period))
                         : r_deadline;
        n_link.tok    = i_link.tok;
        n_link.min_dl = (i_active && (w_new_dl < i_link.min_dl)) ? w_new_dl
                                                                 : i_link.min_dl;
        n_fire        = i_link.tok && w_due;
    end

    always_ff @(posedge i_clk) begin
        r_link.min_dl <= n_link.min_dl;
        if (!i_rst_n) begin
            r_link.tok <= 1'b0;
            r_fire     <= 1'b0;
        end else begin
            r_link.tok <= n_link.tok;
            r_fire     <= n_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_deadline <= i_wr_deadline;
            r_period   <= i_wr_period;
        end else if (i_link.tok && w_due) begin
            r_deadline <= w_new_dl;
        end
    end

    assign o_link = r_link;
    assign o_fire = r_fire;

endmodule

### rtl/multi_channel_periodic_timer.sv
// ============================================================================
// multi_channel_periodic_timer
// Periodic timer with CHANNELS slots kept in a row of cells.
// ============================================================================
// Usage: drive an item on i_func, i_now_ms and i_period_ms with start; it is
// taken at a clock edge where start is high and busy is low. Results appear
// one per cycle on o_kind, o_channel, o_table_full and o_last, each for a
// single cycle marked by o_strobe; the receiver must take them as they come.
// An add is answered in the cycle after it is taken and busy stays low, so
// adds can be issued every cycle. An evaluated tick that finds a due
// deadline sends a token down the cell row, one cell per cycle, and busy
// stays high through the sweep and the drain. The fired channels come out
// in index order, each word held back until the next fired channel or the
// end of the scan, so the last one, flagged, comes out in the same cycle
// as busy falls. Ticks that are early or find nothing due leave busy low
// and give no result. The quantum register is written through
// i_cfg_valid/o_cfg_ready, which is always ready; write it only while the
// block is idle. Reset empties the channel table, sets the quantum to 100 ms,
// the next check time to zero and the earliest deadline to the time maximum.
// ============================================================================
module multi_channel_periodic_timer #(
    parameter int CHANNELS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_func,
    input  logic [mcpt_pkg::TIME_W-1:0]       i_now_ms,
    input  logic [mcpt_pkg::PERIOD_W-1:0]     i_period_ms,
    output logic                              o_strobe,
    output logic                              o_kind,
    output logic [mcpt_pkg::CHAN_W-1:0]       o_channel,
    output logic                              o_table_full,
    output logic                              o_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mcpt_pkg::PERIOD_W-1:0]     i_cfg_data
);

    localparam int CNT_W = $clog2(CHANNELS + 1);
    localparam int POS_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    mcpt_pkg::t_state                r_state, n_state;
    logic [CNT_W-1:0]                r_count, n_count;
    logic [mcpt_pkg::TIME_W-1:0]     r_next_check, n_next_check;
    logic [mcpt_pkg::TIME_W-1:0]     r_earliest, n_earliest;
    logic [mcpt_pkg::PERIOD_W-1:0]   r_quantum;
    logic [mcpt_pkg::TIME_W-1:0]     r_now, n_now;
    logic                            r_launch, n_launch;
    logic [POS_W-1:0]                r_pos, n_pos;
    logic                            r_pend_v, n_pend_v;
    logic [POS_W-1:0]                r_pend_ch, n_pend_ch;
    logic                            r_strobe, n_strobe;
    logic                            r_kind, n_kind;
    logic [mcpt_pkg::CHAN_W-1:0]     r_channel, n_channel;
    logic                            r_full, n_full;
    logic                            r_last, n_last;

    logic                            w_accept;
    logic                            w_add_wr;
    logic [mcpt_pkg::TIME_W-1:0]     w_add_dl;
    logic                            w_any_fire;
    logic [CHANNELS-1:0]             w_fire;
    mcpt_pkg::t_link                 w_link [CHANNELS+1];

    assign w_accept    = start && (r_state == mcpt_pkg::S_IDLE);
    assign w_add_dl    = mcpt_pkg::sat_add(i_now_ms, mcpt_pkg::TIME_W'(i_period_ms));
    assign w_add_wr    = w_accept && (i_func == mcpt_pkg::FUNC_ADD)
                         && (r_count < CNT_W'(CHANNELS));
    assign w_any_fire  = |w_fire;

    assign w_link[0].tok    = r_launch;
    assign w_link[0].min_dl = mcpt_pkg::TIME_MAX;

    for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
        mcpt_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_active      (CNT_W'(g) < r_count),
            .i_now         (r_now),
            .i_wr          (w_add_wr && (r_count == CNT_W'(g))),
            .i_wr_deadline (w_add_dl),
            .i_wr_period   (i_period_ms),
            .i_link        (w_link[g]),
            .o_link        (w_link[g+1]),
            .o_fire        (w_fire[g])
        );
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_next_check = r_next_check;
        n_earliest   = r_earliest;
        n_now        = r_now;
        n_launch     = 1'b0;
        n_pos        = r_pos;
        n_pend_v     = r_pend_v;
        n_pend_ch    = r_pend_ch;
        n_strobe     = 1'b0;
        n_kind       = r_kind;
        n_channel    = r_channel;
        n_full       = r_full;
        n_last       = r_last;
        case (r_state)
            mcpt_pkg::S_IDLE: begin
                if (w_accept && (i_func == mcpt_pkg::FUNC_ADD)) begin
                    n_strobe = 1'b1;
                    n_kind   = mcpt_pkg::KIND_ADD;
                    n_last   = 1'b1;
                    if (w_add_wr) begin
                        n_full    = 1'b0;
                        n_channel = mcpt_pkg::CHAN_W'(r_count);
                        n_count   = r_count + CNT_W'(1);
                        if (w_add_dl < r_earliest) begin
                            n_earliest = w_add_dl;
                        end
                    end else begin
                        n_full    = 1'b1;
                        n_channel = '0;
                    end
                end else if (w_accept && (i_now_ms >= r_next_check)) begin
                    n_next_check = mcpt_pkg::sat_add(i_now_ms,
                                                     mcpt_pkg::TIME_W'(r_quantum));
                    if (r_earliest <= i_now_ms) begin
                        n_now    = i_now_ms;
                        n_launch = 1'b1;
                        n_pos    = '0;
                        n_pend_v = 1'b0;
                        n_state  = mcpt_pkg::S_SWEEP;
                    end
                end
            end
            mcpt_pkg::S_SWEEP: begin
                // The cell at r_pos shows its fire flag while r_launch is low.
                if (!r_launch) begin
                    n_pos = r_pos + POS_W'(1);
                end
                // A fired channel is held back until the next one fires or the scan ends,
                // so that the last one can be flagged.
                if (w_any_fire) begin
                    if (r_pend_v) begin
                        n_strobe  = 1'b1;
                        n_kind    = mcpt_pkg::KIND_FIRE;
                        n_full    = 1'b0;
                        n_last    = 1'b0;
                        n_channel = mcpt_pkg::CHAN_W'(r_pend_ch);
                    end
                    n_pend_v  = 1'b1;
                    n_pend_ch = r_pos;
                end
                if (w_link[CHANNELS].tok) begin
                    n_earliest = w_link[CHANNELS].min_dl;
                    n_state    = mcpt_pkg::S_DRAIN;
                end
            end
            mcpt_pkg::S_DRAIN: begin
                if (r_pend_v) begin
                    n_strobe  = 1'b1;
                    n_kind    = mcpt_pkg::KIND_FIRE;
                    n_full    = 1'b0;
                    n_last    = 1'b1;
                    n_channel = mcpt_pkg::CHAN_W'(r_pend_ch);
                end
                n_pend_v = 1'b0;
                n_state  = mcpt_pkg::S_IDLE;
            end
            default: begin
                n_state = mcpt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mcpt_pkg::S_IDLE;
            r_count      <= '0;
            r_next_check <= '0;
            r_earliest   <= mcpt_pkg::TIME_MAX;
            r_quantum    <= mcpt_pkg::QUANTUM_RESET;
            r_launch     <= 1'b0;
            r_pend_v     <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_next_check <= n_next_check;
            r_earliest   <= n_earliest;
            r_launch     <= n_launch;
            r_pend_v     <= n_pend_v;
            r_strobe     <= n_strobe;
            if (i_cfg_valid) begin
                r_quantum <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_now     <= n_now;
        r_pos     <= n_pos;
        r_pend_ch <= n_pend_ch;
        r_kind    <= n_kind;
        r_channel <= n_channel;
        r_full    <= n_full;
        r_last    <= n_last;
    end

    assign busy         = (r_state != mcpt_pkg::S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_kind       = r_kind;
    assign o_channel    = r_channel;
    assign o_table_full = r_full;
    assign o_last       = r_last;
    assign o_cfg_ready  = 1'b1;

endmodule

### rtl/mcpt_checker.sv
// ============================================================================
// mcpt_checker
// Port-level checks of the multi-channel periodic timer, bound to the top.
// ============================================================================
module mcpt_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  logic                              i_func,
    input  logic                              o_strobe,
    input  logic                              o_kind,
    input  logic [mcpt_pkg::CHAN_W-1:0]       o_channel,
    input  logic                              o_table_full,
    input  logic                              o_last
);

    // An accepted add is answered in the next cycle.
    a_add_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_func == mcpt_pkg::FUNC_ADD)
        |=> o_strobe && (o_kind == mcpt_pkg::KIND_ADD))
        else $error("add word not answered in the next cycle");

    // An add reply is always the only word of its item.
    a_add_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_kind == mcpt_pkg::KIND_ADD) |-> o_last)
        else $error("add reply without last flag");

    // The full flag only comes with an add reply on channel zero.
    a_full_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_table_full
        |-> (o_kind == mcpt_pkg::KIND_ADD) && (o_channel == '0))
        else $error("malformed full reply");

    // A fire word never appears while the block was idle in the cycle before.
    a_fire_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_kind == mcpt_pkg::KIND_FIRE) |-> $past(busy))
        else $error("fire word outside a scan");

    // Nothing comes out right after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_strobe)
        else $error("word issued right after reset");

endmodule

bind multi_channel_periodic_timer mcpt_checker u_mcpt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_func       (i_func),
    .o_strobe     (o_strobe),
    .o_kind       (o_kind),
    .o_channel    (o_channel),
    .o_table_full (o_table_full),
    .o_last       (o_last)
);

### bench/timer_scoreboard.sv
// ============================================================================
// timer_scoreboard
// Watches the command, configuration and result channels of the periodic
// timer. It keeps its own copy of the channel table, works out the words that
// each accepted command should produce and compares every result word, field
// by field, with the oldest one still expected.
// ============================================================================
module timer_scoreboard #(
    parameter int CHANNELS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_busy,
    input  logic                              i_func,
    input  logic [mcpt_pkg::TIME_W-1:0]       i_now_ms,
    input  logic [mcpt_pkg::PERIOD_W-1:0]     i_period_ms,
    input  logic                              i_strobe,
    input  logic                              i_kind,
    input  logic [mcpt_pkg::CHAN_W-1:0]       i_channel,
    input  logic                              i_table_full,
    input  logic                              i_last,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [mcpt_pkg::PERIOD_W-1:0]     i_cfg_data,
    output int                                o_errors,
    output int                                o_waiting,
    output int                                o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                        kind;
        logic [mcpt_pkg::CHAN_W-1:0] channel;
        logic                        table_full;
        logic                        last;
    } t_timer_word;

    t_timer_word                   expected_words[$];
    t_timer_word                   want;
    t_timer_word                   got;
    logic [mcpt_pkg::PERIOD_W-1:0] quantum;
    logic [mcpt_pkg::TIME_W-1:0]   next_check;
    logic [mcpt_pkg::TIME_W-1:0]   earliest;
    logic [mcpt_pkg::TIME_W-1:0]   deadline [CHANNELS];
    logic [mcpt_pkg::PERIOD_W-1:0] interval [CHANNELS];
    int                            used_slots;
    int                            errors  = 0;
    int                            results = 0;

    function automatic logic [mcpt_pkg::TIME_W-1:0] clamp_add(
        input logic [mcpt_pkg::TIME_W-1:0] a,
        input logic [mcpt_pkg::TIME_W-1:0] b);
        logic [mcpt_pkg::TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, mcpt_pkg::TIME_MAX}) ? mcpt_pkg::TIME_MAX
                                                : s[mcpt_pkg::TIME_W-1:0];
    endfunction

    function automatic t_timer_word make_word(input logic kind,
                                              input logic [mcpt_pkg::CHAN_W-1:0] ch,
                                              input logic full, input logic fin);
        t_timer_word w;
        w.kind       = kind;
        w.channel    = ch;
        w.table_full = full;
        w.last       = fin;
        return w;
    endfunction

    task automatic predict_words(input logic f, input logic [mcpt_pkg::TIME_W-1:0] t,
                                 input logic [mcpt_pkg::PERIOD_W-1:0] p);
        logic [mcpt_pkg::TIME_W-1:0] lo;
        logic [CHANNELS-1:0]         due;
        int                          top_idx;
        int                          i;
        due     = '0;
        top_idx = -1;
        if (f == mcpt_pkg::FUNC_ADD) begin
            if (used_slots >= CHANNELS) begin
                expected_words.push_back(make_word(mcpt_pkg::KIND_ADD, '0, 1'b1, 1'b1));
            end else begin
                interval[used_slots] = p;
                deadline[used_slots] = clamp_add(t, mcpt_pkg::TIME_W'(p));
                if (deadline[used_slots] < earliest)
                    earliest = deadline[used_slots];
                expected_words.push_back(make_word(mcpt_pkg::KIND_ADD,
                                                   mcpt_pkg::CHAN_W'(used_slots),
                                                   1'b0, 1'b1));
                used_slots++;
            end
        end else if (t >= next_check) begin
            next_check = clamp_add(t, mcpt_pkg::TIME_W'(quantum));
            if (earliest <= t) begin
                // The minimum is taken over every used slot, after the due ones moved on.
                lo = mcpt_pkg::TIME_MAX;
                for (i = 0; i < used_slots; i++) begin
                    if (deadline[i] <= t) begin
                        deadline[i] = clamp_add(deadline[i], mcpt_pkg::TIME_W'(interval[i]));
                        due[i]      = 1'b1;
                        top_idx     = i;
                    end
                    if (deadline[i] < lo)
                        lo = deadline[i];
                end
                earliest = lo;
                for (i = 0; i <= top_idx; i++) begin
                    if (due[i])
                        expected_words.push_back(make_word(mcpt_pkg::KIND_FIRE,
                                                           mcpt_pkg::CHAN_W'(i), 1'b0,
                                                           i == top_idx));
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            expected_words.delete();
            quantum    = mcpt_pkg::QUANTUM_RESET;
            next_check = '0;
            earliest   = mcpt_pkg::TIME_MAX;
            used_slots = 0;
        end else begin
            if (i_strobe) begin
                results++;
                got = make_word(i_kind, i_channel, i_table_full, i_last);
                if (expected_words.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: unexpected word kind=%0b channel=%0d full=%0b last=%0b",
                                 $realtime, got.kind, got.channel, got.table_full, got.last);
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    if (got.kind !== want.kind || got.channel !== want.channel ||
                        got.table_full !== want.table_full || got.last !== want.last) begin
                        if (errors < 10)
                            $display({"%0t: word mismatch, expected kind=%0b channel=%0d ",
                                      "full=%0b last=%0b, got kind=%0b channel=%0d ",
                                      "full=%0b last=%0b"}, $realtime,
                                     want.kind, want.channel, want.table_full, want.last,
                                     got.kind, got.channel, got.table_full, got.last);
                        errors++;
                    end
                end
            end
            // A command taken at this edge still sees the old quantum.
            if (i_start && !i_busy)
                predict_words(i_func, i_now_ms, i_period_ms);
            if (i_cfg_valid && i_cfg_ready)
                quantum = i_cfg_data;
        end
        o_errors  <= errors;
        o_waiting <= expected_words.size();
        o_results <= results;
    end

endmodule

### bench/tb_top.sv
// ============================================================================
// tb_top
// Drives the periodic timer with a short directed sequence that fills the
// channel table and then with random tick and add commands under several
// quantum settings, ending at the time maximum. The scoreboard beside the
// block predicts and checks every result word.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS     = 16;
    localparam int LIMIT_CYCLES = 200000;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          start       = 1'b0;
    logic                          func        = mcpt_pkg::FUNC_TICK;
    logic [mcpt_pkg::TIME_W-1:0]   now_ms      = '0;
    logic [mcpt_pkg::PERIOD_W-1:0] period_ms   = '0;
    logic                          cfg_valid   = 1'b0;
    logic [mcpt_pkg::PERIOD_W-1:0] cfg_data    = '0;
    logic                          busy;
    logic                          strobe;
    logic                          kind;
    logic [mcpt_pkg::CHAN_W-1:0]   channel;
    logic                          table_full;
    logic                          last;
    logic                          cfg_ready;
    int                            errors;
    int                            waiting;
    int                            result_total;
    int                            cycles      = 0;
    int                            idle_pct    = 30;
    int                            adds_sent   = 0;
    int                            ticks_sent  = 0;
    int                            cfg_writes  = 0;
    logic [mcpt_pkg::TIME_W-1:0]   tick_ms     = '0;

    always #5 clk = ~clk;

    multi_channel_periodic_timer #(
        .CHANNELS(CHANNELS)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .start       (start),
        .busy        (busy),
        .i_func      (func),
        .i_now_ms    (now_ms),
        .i_period_ms (period_ms),
        .o_strobe    (strobe),
        .o_kind      (kind),
        .o_channel   (channel),
        .o_table_full(table_full),
        .o_last      (last),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    timer_scoreboard #(
        .CHANNELS(CHANNELS)
    ) scoreboard (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_func      (func),
        .i_now_ms    (now_ms),
        .i_period_ms (period_ms),
        .i_strobe    (strobe),
        .i_kind      (kind),
        .i_channel   (channel),
        .i_table_full(table_full),
        .i_last      (last),
        .i_cfg_valid (cfg_valid),
        .i_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_errors    (errors),
        .o_waiting   (waiting),
        .o_results   (result_total)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("tb_top failed");
            $finish;
        end
    end

    function automatic logic [mcpt_pkg::TIME_W-1:0] random_time();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[mcpt_pkg::TIME_W-1:0];
    endfunction

    // Offers one command word, after a random gap, and returns at the edge
    // that takes it.
    task automatic send_command(input logic f, input logic [mcpt_pkg::TIME_W-1:0] t,
                                input logic [mcpt_pkg::PERIOD_W-1:0] p);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        func      <= f;
        now_ms    <= t;
        period_ms <= p;
        do @(posedge clk); while (busy);
        if (f == mcpt_pkg::FUNC_ADD)
            adds_sent++;
        else
            ticks_sent++;
    endtask

    // Holds off until every expected word has come and the scan has ended.
    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge clk); while (waiting != 0 || busy);
        repeat (CHANNELS + 4) @(posedge clk);
    endtask

    task automatic write_quantum(input logic [mcpt_pkg::PERIOD_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Mostly ticks that move time forward, with rejected adds and stale
    // ticks mixed in as noise.
    task automatic run_random(input int count, input int step, input bit jumps);
        int i;
        int pick;
        for (i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                send_command(mcpt_pkg::FUNC_ADD, random_time(), $urandom);
            end else if (pick < 20) begin
                send_command(mcpt_pkg::FUNC_TICK, random_time() % (tick_ms + 48'd1),
                             $urandom);
            end else begin
                if (jumps && $urandom_range(3) == 0)
                    tick_ms = tick_ms + 48'h1_0000_0000
                              + mcpt_pkg::TIME_W'($urandom_range(step));
                else
                    tick_ms = tick_ms + mcpt_pkg::TIME_W'($urandom_range(step));
                send_command(mcpt_pkg::FUNC_TICK, tick_ms, $urandom);
            end
            if ($urandom_range(99) < 4)
                wait_drained();
        end
    endtask

    initial begin
        int i;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset quantum of 100 ms.
        send_command(mcpt_pkg::FUNC_TICK, 48'd0, $urandom);
        send_command(mcpt_pkg::FUNC_ADD, 48'd0, 32'd150);
        send_command(mcpt_pkg::FUNC_TICK, 48'd50, $urandom);
        send_command(mcpt_pkg::FUNC_TICK, 48'd100, $urandom);
        send_command(mcpt_pkg::FUNC_ADD, 48'd100, 32'd0);
        send_command(mcpt_pkg::FUNC_ADD, mcpt_pkg::TIME_MAX - 48'd3, '1);
        send_command(mcpt_pkg::FUNC_ADD, 48'd100, '1);
        send_command(mcpt_pkg::FUNC_TICK, 48'd200, $urandom);
        for (i = 4; i < CHANNELS; i++)
            send_command(mcpt_pkg::FUNC_ADD, 48'd200, $urandom_range(120, 1));
        send_command(mcpt_pkg::FUNC_ADD, mcpt_pkg::TIME_MAX, '1);
        tick_ms = 48'd300;
        send_command(mcpt_pkg::FUNC_TICK, tick_ms, $urandom);

        write_quantum('0);
        run_random(35, 40, 1'b0);

        write_quantum(32'd37);
        idle_pct = 0;
        run_random(35, 80, 1'b0);

        write_quantum('1);
        idle_pct = 30;
        run_random(25, 50, 1'b1);

        // At the time maximum every channel is due, the saturated one too,
        // and the second tick fires them all again.
        send_command(mcpt_pkg::FUNC_TICK, mcpt_pkg::TIME_MAX, $urandom);
        send_command(mcpt_pkg::FUNC_TICK, mcpt_pkg::TIME_MAX, $urandom);
        send_command(mcpt_pkg::FUNC_TICK, 48'd0, $urandom);
        send_command(mcpt_pkg::FUNC_ADD, 48'd0, 32'd0);
        wait_drained();

        $display("Sent %0d adds and %0d ticks under %0d quantum settings; %0d result words seen.",
                 adds_sent, ticks_sent, cfg_writes + 1, result_total);
        $display("Table filled to %0d channels, finishing with full-table fires at the time max.",
                 CHANNELS);
        if (errors == 0 && waiting == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

### multi_channel_periodic_timer.f
rtl/mcpt_pkg.sv
rtl/mcpt_cell.sv
rtl/multi_channel_periodic_timer.sv
rtl/mcpt_checker.sv
bench/timer_scoreboard.sv
bench/tb_top.sv
